@@ rtl/mpv_pkg.sv @@
package mpv_pkg;

	localparam logic [1:0] KIND_LEAF    = 2'd0;
	localparam logic [1:0] KIND_SIBLING = 2'd1;
	localparam logic [1:0] KIND_ROOT    = 2'd2;

	localparam int unsigned Rounds = 64;

	typedef logic [31:0] word32_t;

	localparam word32_t SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word32_t sha_k(input logic [5:0] r);
		word32_t k;
		case (r)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word32_t rotr(input word32_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

@@ rtl/mpv_in_if.sv @@
interface mpv_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  word_index;
	logic [63:0] data_word;
	logic        sibling_left;

	modport source (output valid, kind, word_index, data_word, sibling_left, input ready);
	modport sink (input valid, kind, word_index, data_word, sibling_left, output ready);
endinterface

@@ rtl/mpv_out_if.sv @@
interface mpv_out_if;
	logic valid;
	logic ready;
	logic root_match;

	modport source (output valid, root_match, input ready);
	modport sink (input valid, root_match, output ready);
endinterface

@@ rtl/merkle_proof_verify_core.sv @@
// Leaf words and non-final sibling words are simply stored; a final sibling word,
// or the first root word of a proof with no sibling, runs two SHA-256 compressions on
// one shared round unit, each of 64 rounds followed by a chain-add step.
// A root word with index 3 shows its result the cycle after it is accepted.
// Throughput: one request at a time; ready drops while hashing or while a result waits.
// Reset (arst_n low) clears the hash to zero, state to idle and the output valid.
module merkle_proof_verify_core
	import mpv_pkg::*;
(
	input logic clk,
	input logic arst_n,
	mpv_in_if.sink in,
	mpv_out_if.source out
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;

	logic [1:0]  state_q;
	logic [5:0]  round_q;
	logic        block_q;      // 0 data block, 1 padding block
	logic        left_q;
	logic        dup_q;        // root with no sibling hashes the current value paired with itself
	logic        cmp_pend_q;   // root word 0 waiting for hash before compare
	logic [63:0] root_word_q;
	logic [63:0] cur_q [4];
	logic [63:0] sib_q [4];
	logic        seen_q;
	logic        match_q;
	word32_t     cv_q [8];
	word32_t     v_q [8];
	word32_t     w_q [16];
	logic        ovalid_q;
	logic        omatch_q;

	logic        acc;
	word32_t     wnew, wcur, t1, t2, s0, s1, e, a;
	word32_t     blk [16];
	logic [3:0]  ri;

	assign in.ready = (state_q == ST_IDLE) && !ovalid_q;
	assign acc = in.valid && in.ready;
	assign out.valid = ovalid_q;
	assign out.root_match = omatch_q;

	// message block, data words first
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			logic [63:0] x, y;
			x = left_q ? sib_q[i] : cur_q[i];
			y = (left_q || dup_q) ? cur_q[i] : sib_q[i];
			blk[2*i]     = x[63:32];
			blk[2*i+1]   = x[31:0];
			blk[8+2*i]   = y[63:32];
			blk[8+2*i+1] = y[31:0];
		end
	end

	// shared round unit
	always_comb begin
		ri = round_q[3:0];
		s0 = rotr(w_q[4'(ri + 4'd1)], 7) ^ rotr(w_q[4'(ri + 4'd1)], 18)
			^ (w_q[4'(ri + 4'd1)] >> 3);
		s1 = rotr(w_q[4'(ri + 4'd14)], 17) ^ rotr(w_q[4'(ri + 4'd14)], 19)
			^ (w_q[4'(ri + 4'd14)] >> 10);
		wnew = w_q[ri] + s0 + w_q[4'(ri + 4'd9)] + s1;
		wcur = (round_q >= 6'd16) ? wnew : w_q[ri];
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + sha_k(round_q) + wcur;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			block_q <= 1'b0;
			cmp_pend_q <= 1'b0;
			seen_q <= 1'b0;
			match_q <= 1'b1;
			ovalid_q <= 1'b0;
			for (int i = 0; i < 4; i++) cur_q[i] <= '0;
		end else begin
			if (out.valid && out.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (in.kind)
							KIND_LEAF: begin
								if (in.word_index == 2'd0) begin
									seen_q <= 1'b0;
									match_q <= 1'b1;
								end
								cur_q[in.word_index] <= in.data_word;
							end
							KIND_SIBLING: begin
								sib_q[in.word_index] <= in.data_word;
								if (in.word_index == 2'd3) begin
									left_q <= in.sibling_left;
									dup_q <= 1'b0;
									state_q <= ST_ADD;
									round_q <= '1;
									block_q <= 1'b1;
									cmp_pend_q <= 1'b0;
								end
							end
							KIND_ROOT: begin
								if (in.word_index == 2'd0 && !seen_q) begin
									left_q <= 1'b0;
									dup_q <= 1'b1;
									state_q <= ST_ADD;
									round_q <= '1;
									block_q <= 1'b1;
									cmp_pend_q <= 1'b1;
									root_word_q <= in.data_word;
								end else begin
									if (in.word_index == 2'd0)
										match_q <= (cur_q[0] == in.data_word);
									else if (cur_q[in.word_index] != in.data_word)
										match_q <= 1'b0;
									if (in.word_index == 2'd3) begin
										ovalid_q <= 1'b1;
										omatch_q <= match_q
											&& (cur_q[3] == in.data_word);
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_ROUND: begin
					if (round_q >= 6'd16) w_q[ri] <= wnew;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					round_q <= round_q + 6'd1;
					if (round_q == 6'(Rounds - 1)) state_q <= ST_ADD;
				end
				ST_ADD: begin
					// fold working vars into chain (skipped on entry), load next block or finish
					if (block_q) begin
						// start data block from IV, or finish
						if (round_q == '1) begin
							for (int i = 0; i < 8; i++) begin
								cv_q[i] <= SHA_IV[i];
								v_q[i] <= SHA_IV[i];
							end
							for (int i = 0; i < 16; i++) w_q[i] <= blk[i];
							block_q <= 1'b0;
							round_q <= '0;
							state_q <= ST_ROUND;
						end else begin
							for (int i = 0; i < 4; i++)
								cur_q[i] <= {cv_q[2*i] + v_q[2*i], cv_q[2*i+1] + v_q[2*i+1]};
							seen_q <= 1'b1;
							state_q <= ST_IDLE;
							if (cmp_pend_q) begin
								match_q <= ({cv_q[0] + v_q[0], cv_q[1] + v_q[1]}
									== root_word_q);
								cmp_pend_q <= 1'b0;
							end
						end
					end else begin
						for (int i = 0; i < 8; i++) begin
							cv_q[i] <= cv_q[i] + v_q[i];
							v_q[i] <= cv_q[i] + v_q[i];
						end
						for (int i = 0; i < 16; i++)
							w_q[i] <= (i == 0) ? 32'h80000000 :
								(i == 15) ? 32'd512 : 32'd0;
						block_q <= 1'b1;
						round_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
